@@ rtl/core/ilt_pkg.sv @@
// ----------------------------------------------------------------------------
// ilt_pkg
// shared constants for the indexed list table: sizes, operation and status codes
// ----------------------------------------------------------------------------
`default_nettype none

package ilt_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int MODE_W     = 3;
  localparam int POS_W      = 5;
  localparam int FPOS_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 48;

  localparam logic [MODE_W-1:0] MODE_APPEND      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE_LAST = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE_AT   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ        = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FIND        = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_LOAD     = 8'b0000_0010,
    S_TAKE     = 8'b0000_0100,
    S_CMP      = 8'b0000_1000,
    S_SHIFT_RD = 8'b0001_0000,
    S_SHIFT_WR = 8'b0010_0000,
    S_PUT      = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/indexed_list_table.sv @@
// ----------------------------------------------------------------------------
// indexed_list_table
// fixed-capacity ordered list with append, insert, remove, read and find
//
//   channel   dir   fields (lowest bit first)
//   s_axis    in    mode[2:0] position[7:3] value[39:8]
//   m_axis    out   data_out[31:0] found_position[35:32] found[36]
//                   status[38:37] entry_count[43:39] zero[47:44]
//
// one word at a time through a single-port entry memory with registered read
// failed checks and no-ops go straight to done; append puts the value; read and remove last
// load then take the entry; insert shifts later entries up then puts; remove at loads, takes,
// then shifts later entries down (a read and a write per entry); find compares each entry scanned
// rst clears the count and control; entry contents are not cleared
// input is taken only when idle; a held result stalls only the final step
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_table
  import ilt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // mode, position, value
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata    // data_out, found_position, found, status, entry_count
);

  state_t                  state;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        cur;
  logic [MODE_W-1:0]       op;
  logic [POS_W-1:0]        pos;
  logic [DATA_WIDTH-1:0]   val;

  logic [DATA_WIDTH-1:0]   res_data;
  logic                    res_found;
  logic [FPOS_W-1:0]       res_fpos;
  logic [STATUS_W-1:0]     res_status;

  logic [DATA_WIDTH-1:0]   mem [CAPACITY];
  logic [DATA_WIDTH-1:0]   rd_data;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    wr_en;
  logic [DATA_WIDTH-1:0]   wr_data;

  logic [CNT_W-1:0]        nxt;
  logic                    out_free;

  logic [MODE_W-1:0]       in_mode;
  logic [POS_W-1:0]        in_pos;
  logic [DATA_WIDTH-1:0]   in_val;
  logic                    full;
  logic                    empty;

  assign in_mode = s_tdata[2:0];
  assign in_pos  = s_tdata[7:3];
  assign in_val  = s_tdata[39:8];

  assign full  = (count == CNT_W'(CAPACITY));
  assign empty = (count == '0);

  // shared step unit: down for insert, up for remove and scan
  assign nxt = (op == MODE_INSERT) ? CNT_W'(cur - 1'b1) : CNT_W'(cur + 1'b1);

  assign rd_addr  = (state == S_SHIFT_RD) ? nxt[ADDR_W-1:0] : cur[ADDR_W-1:0];
  assign wr_en    = (state == S_PUT) || (state == S_SHIFT_WR);
  assign wr_data  = (state == S_PUT) ? val : rd_data;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cur[ADDR_W-1:0]] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op         <= in_mode;
            pos        <= in_pos;
            val        <= in_val;
            res_data   <= '0;
            res_found  <= 1'b0;
            res_fpos   <= '0;
            unique case (in_mode)
              MODE_APPEND: begin
                if (full) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  cur        <= count;
                  state      <= S_PUT;
                end
              end
              MODE_INSERT: begin
                if (full) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else if (in_pos > count) begin
                  res_status <= ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  cur        <= count;
                  state      <= (in_pos == count) ? S_PUT : S_SHIFT_RD;
                end
              end
              MODE_REMOVE_LAST: begin
                if (empty) begin
                  res_status <= ST_EMPTY;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  cur        <= CNT_W'(count - 1'b1);
                  state      <= S_LOAD;
                end
              end
              MODE_REMOVE_AT, MODE_READ: begin
                if (empty) begin
                  res_status <= ST_EMPTY;
                  state      <= S_DONE;
                end else if (in_pos >= count) begin
                  res_status <= ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  cur        <= in_pos;
                  state      <= S_LOAD;
                end
              end
              MODE_FIND: begin
                res_status <= ST_OK;
                if (!empty) begin
                  cur   <= '0;
                  state <= S_LOAD;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_LOAD: begin
          state <= (op == MODE_FIND) ? S_CMP : S_TAKE;
        end
        S_TAKE: begin
          res_data <= rd_data;
          if (op != MODE_READ) begin
            count <= CNT_W'(count - 1'b1);
          end
          if (op == MODE_REMOVE_AT && cur != CNT_W'(count - 1'b1)) begin
            state <= S_SHIFT_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_CMP: begin
          if (rd_data == val) begin
            res_found <= 1'b1;
            res_fpos  <= cur[FPOS_W-1:0];
            state     <= S_DONE;
          end else if (nxt == count) begin
            state <= S_DONE;
          end else begin
            cur   <= nxt;
            state <= S_LOAD;
          end
        end
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          cur <= nxt;
          if (op == MODE_INSERT) begin
            state <= (nxt == CNT_W'(pos)) ? S_PUT : S_SHIFT_RD;
          end else begin
            state <= (nxt == count) ? S_DONE : S_SHIFT_RD;
          end
        end
        S_PUT: begin
          count <= CNT_W'(count + 1'b1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= {4'b0000, count, res_status, res_found, res_fpos, res_data};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !wr_en)
    else $error("entry write outside an operation");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    !(state == S_PUT || state == S_TAKE) |=> $stable(count))
    else $error("count changed outside put or take");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result word raised outside done");

endmodule

`default_nettype wire
